// ===== rtl/biquad_cascade_iir_filter_macros.svh =====
// assertion macros shared by the biquad cascade rtl
`ifndef BIQUAD_CASCADE_IIR_FILTER_MACROS_SVH
`define BIQUAD_CASCADE_IIR_FILTER_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define BQC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define BQC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bqc_pkg.sv =====
// shared constants, codes and types of the biquad cascade
package bqc_pkg;

   localparam int MAX_STAGES   = 8;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 20;
   localparam int COEF_FRAC    = 16;
   localparam int DELAY_WIDTH  = 32;
   localparam int NUM_COEFS    = 5;

   localparam int COEF_DEPTH = NUM_COEFS * MAX_STAGES;
   localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
   localparam int STAGE_AW   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
   localparam int CNT_W      = $clog2(MAX_STAGES + 1);

   localparam int ACTIVE_WIDTH = 4;
   localparam int CSR_DW       = 32;
   localparam int CSR_AW       = 3;

   // csr word index of the stage count register
   localparam logic REG_ACTIVE_STAGES = 1'b0;

   // transaction function codes
   localparam logic [1:0] FUNC_FILTER = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // one step per product of a section, then the delay write-back
   typedef enum logic [2:0] {
      STEP_B0,
      STEP_B1,
      STEP_B2,
      STEP_A1,
      STEP_A2,
      STEP_WB
   } step_type;

   typedef struct packed {
      logic     load_x;
      logic     run;
      step_type step;
   } alu_ctl_type;

endpackage

// ===== rtl/biquad_cascade_iir_filter.sv =====
// top level of the cascaded transposed direct form ii biquad filter
//
// Each request transaction carries a function code: filter one Q1.15 sample through the
// first active_stages sections (clamped to the number of sections built), write one Q4.16
// coefficient, or clear all delay states. Only a filter transaction returns a response.
// One shared 20x16 multiplier evaluates the five products of a section, one per cycle,
// from a single-port coefficient memory with registered read data, so a section runs
// in six steps (five products and the delay write-back). A filter transaction stalls
// new requests until its result is in the output register; writes and clears leave the
// block idle. Sections are processed strictly in order and each section's delay pair is
// read before its evaluation and written once at its end, so read and write of the same
// entry never overlap. Coefficients and delay states come out of reset as zero through
// per-entry valid bits; a clear drops all delay valid bits at once, so no clearing pass
// is needed. The response sits in an output register, and a new request can be taken
// while a finished sample waits to be collected.
`include "biquad_cascade_iir_filter_macros.svh"

module biquad_cascade_iir_filter (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [1:0]                              req_func,
   input  logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic [2:0]                              req_stage_select,
   input  logic [2:0]                              req_coef_select,
   input  logic signed [bqc_pkg::COEF_WIDTH-1:0]   req_coef_value,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] rsp_sample_out,
   // csr port
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [bqc_pkg::CSR_AW-1:0]              csr_paddr,
   input  logic [bqc_pkg::CSR_DW-1:0]              csr_pwdata,
   output logic [bqc_pkg::CSR_DW-1:0]              csr_prdata,
   output logic                                    csr_pready
);

   localparam int SW = bqc_pkg::SAMPLE_WIDTH;
   localparam int CW = bqc_pkg::COEF_WIDTH;
   localparam int DW = bqc_pkg::DELAY_WIDTH;
   localparam int AW = bqc_pkg::ACTIVE_WIDTH;

   // ---------------------------------------------------------------- csr
   logic [AW-1:0] active_ff;
   logic [AW-1:0] active_in;
   logic          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      active_in = active_ff;
      if (csr_wr && csr_paddr[2] == bqc_pkg::REG_ACTIVE_STAGES) begin
         active_in = csr_pwdata[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= AW'(1);
      end else begin
         active_ff <= active_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == bqc_pkg::REG_ACTIVE_STAGES) begin
         csr_prdata = {{(bqc_pkg::CSR_DW-AW){1'b0}}, active_ff};
      end
   end

   // number of sections actually run, clamped to what is built
   logic [bqc_pkg::CNT_W-1:0] n_clamp;

   always_comb begin
      if (int'(active_ff) > bqc_pkg::MAX_STAGES) begin
         n_clamp = bqc_pkg::CNT_W'(bqc_pkg::MAX_STAGES);
      end else begin
         n_clamp = bqc_pkg::CNT_W'(active_ff);
      end
   end

   // ---------------------------------------------------------------- control
   bqc_pkg::state_type         state_ff, state_in;
   bqc_pkg::step_type          step_ff, step_in;
   logic [bqc_pkg::STAGE_AW-1:0] stage_ff, stage_in;
   logic [bqc_pkg::CNT_W-1:0]    n_ff, n_in;
   logic [bqc_pkg::COEF_AW-1:0]  caddr_ff, caddr_in;

   logic                         req_acc;
   logic                         out_free;
   logic                         last_stage;
   logic                         rsp_valid_ff;

   logic                         coef_re;
   logic [bqc_pkg::COEF_AW-1:0]  coef_raddr;
   logic                         coef_we;
   logic [bqc_pkg::COEF_AW-1:0]  coef_waddr;
   logic                         dly_re;
   logic [bqc_pkg::STAGE_AW-1:0] dly_raddr;
   logic                         dly_we;
   logic                         dly_clear;
   logic                         rsp_load;
   bqc_pkg::alu_ctl_type         alu_ctl;

   assign req_stall  = (state_ff != bqc_pkg::ST_IDLE);
   assign req_acc    = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_stage = (bqc_pkg::CNT_W'(stage_ff) + bqc_pkg::CNT_W'(1)) == n_ff;

   // coefficient slot of a write transaction
   assign coef_waddr = bqc_pkg::COEF_AW'(int'(req_stage_select) * bqc_pkg::NUM_COEFS
                                         + int'(req_coef_select));

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      stage_in   = stage_ff;
      n_in       = n_ff;
      caddr_in   = caddr_ff;
      coef_re    = 1'b0;
      coef_raddr = caddr_ff;
      coef_we    = 1'b0;
      dly_re     = 1'b0;
      dly_raddr  = '0;
      dly_we     = 1'b0;
      dly_clear  = 1'b0;
      rsp_load   = 1'b0;
      alu_ctl    = '{load_x: 1'b0, run: 1'b0, step: step_ff};

      unique case (state_ff)
         bqc_pkg::ST_IDLE: begin
            if (req_acc) begin
               unique case (req_func)
                  bqc_pkg::FUNC_FILTER: begin
                     alu_ctl.load_x = 1'b1;
                     n_in           = n_clamp;
                     if (n_clamp == '0) begin
                        // no sections: the sample goes straight out
                        state_in = bqc_pkg::ST_DRAIN;
                     end else begin
                        // fetch b0 and the delay pair of the first section
                        coef_re    = 1'b1;
                        coef_raddr = '0;
                        caddr_in   = bqc_pkg::COEF_AW'(1);
                        dly_re     = 1'b1;
                        dly_raddr  = '0;
                        stage_in   = '0;
                        step_in    = bqc_pkg::STEP_B0;
                        state_in   = bqc_pkg::ST_RUN;
                     end
                  end
                  bqc_pkg::FUNC_WRITE: begin
                     coef_we = (int'(req_stage_select) < bqc_pkg::MAX_STAGES)
                            && (int'(req_coef_select) < bqc_pkg::NUM_COEFS);
                  end
                  bqc_pkg::FUNC_CLEAR: begin
                     dly_clear = 1'b1;
                  end
                  default: begin
                     // unknown function: nothing happens
                     dly_clear = 1'b0;
                  end
               endcase
            end
         end

         bqc_pkg::ST_RUN: begin
            alu_ctl.run = 1'b1;
            unique case (step_ff) inside
               bqc_pkg::STEP_B0, bqc_pkg::STEP_B1, bqc_pkg::STEP_B2, bqc_pkg::STEP_A1: begin
                  // prefetch the next coefficient of this section
                  coef_re  = 1'b1;
                  caddr_in = caddr_ff + bqc_pkg::COEF_AW'(1);
                  step_in  = bqc_pkg::step_type'(step_ff + 3'd1);
               end
               bqc_pkg::STEP_A2: begin
                  step_in = bqc_pkg::STEP_WB;
               end
               bqc_pkg::STEP_WB: begin
                  dly_we = 1'b1;
                  if (last_stage) begin
                     state_in = bqc_pkg::ST_DRAIN;
                  end else begin
                     // next section: b0 and its delay pair
                     coef_re   = 1'b1;
                     caddr_in  = caddr_ff + bqc_pkg::COEF_AW'(1);
                     dly_re    = 1'b1;
                     dly_raddr = stage_ff + bqc_pkg::STAGE_AW'(1);
                     stage_in  = stage_ff + bqc_pkg::STAGE_AW'(1);
                     step_in   = bqc_pkg::STEP_B0;
                  end
               end
               default: begin
                  state_in = bqc_pkg::ST_IDLE;
               end
            endcase
         end

         bqc_pkg::ST_DRAIN: begin
            // hand the result to the output register once it is free
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = bqc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bqc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bqc_pkg::ST_IDLE;
         step_ff  <= bqc_pkg::STEP_B0;
         stage_ff <= '0;
         n_ff     <= '0;
         caddr_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         stage_ff <= stage_in;
         n_ff     <= n_in;
         caddr_ff <= caddr_in;
      end
   end

   // ---------------------------------------------------------------- coefficient memory
   // b0 b1 b2 a1 a2 per section, one read port, read data registered
   logic [CW-1:0]                  coef_mem [bqc_pkg::COEF_DEPTH];
   logic [bqc_pkg::COEF_DEPTH-1:0] coef_vld_ff;
   logic [CW-1:0]                  coef_rd_ff;
   logic                           coef_rd_vld_ff;
   logic signed [CW-1:0]           coef_val;

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= req_coef_value;
      end
      if (coef_re) begin
         coef_rd_ff     <= coef_mem[coef_raddr];
         coef_rd_vld_ff <= coef_vld_ff[coef_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
      end else if (coef_we) begin
         coef_vld_ff[coef_waddr] <= 1'b1;
      end
   end

   // a never-written coefficient reads as zero
   assign coef_val = coef_rd_vld_ff ? signed'(coef_rd_ff) : '0;

   // ---------------------------------------------------------------- delay memory
   // z1 in the upper half, z2 in the lower half of each entry
   logic [2*DW-1:0]                dly_mem [bqc_pkg::MAX_STAGES];
   logic [bqc_pkg::MAX_STAGES-1:0] dly_vld_ff;
   logic [2*DW-1:0]                dly_rd_ff;
   logic                           dly_rd_vld_ff;
   logic signed [DW-1:0]           z1_val;
   logic signed [DW-1:0]           z2_val;
   logic signed [DW-1:0]           z1_new;
   logic signed [DW-1:0]           z2_new;

   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[stage_ff] <= {z1_new, z2_new};
      end
      if (dly_re) begin
         dly_rd_ff     <= dly_mem[dly_raddr];
         dly_rd_vld_ff <= dly_vld_ff[dly_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || dly_clear) begin
         dly_vld_ff <= '0;
      end else if (dly_we) begin
         dly_vld_ff[stage_ff] <= 1'b1;
      end
   end

   // cleared or never-written delays read as zero
   assign z1_val = dly_rd_vld_ff ? signed'(dly_rd_ff[2*DW-1:DW]) : '0;
   assign z2_val = dly_rd_vld_ff ? signed'(dly_rd_ff[DW-1:0])    : '0;

   // ---------------------------------------------------------------- datapath
   logic signed [SW-1:0] alu_y;

   bqc_alu u_alu (
      .clock     (clock),
      .ctl       (alu_ctl),
      .sample_in (req_sample_in),
      .coef      (coef_val),
      .z1        (z1_val),
      .z2        (z2_val),
      .y         (alu_y),
      .z1_new    (z1_new),
      .z2_new    (z2_new)
   );

   // ---------------------------------------------------------------- response register
   logic                 rsp_valid_in;
   logic signed [SW-1:0] rsp_sample_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sample_ff <= alu_y;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // ---------------------------------------------------------------- assertions
   // a filter transaction with sections starts at b0 of the first section
   `BQC_ASSERT_NEXT(a_filter_start, req_acc && req_func == bqc_pkg::FUNC_FILTER && n_clamp != '0, state_ff == bqc_pkg::ST_RUN && step_ff == bqc_pkg::STEP_B0 && stage_ff == '0, "filter did not start at the first section")
   // the section counter never passes the latched section count
   `BQC_ASSERT_NOW(a_stage_range, state_ff == bqc_pkg::ST_RUN, bqc_pkg::CNT_W'(stage_ff) < n_ff, "section index beyond the active count")
   // a finished result reaches the output register and the block goes idle
   `BQC_ASSERT_NEXT(a_result_load, state_ff == bqc_pkg::ST_DRAIN && out_free, rsp_valid_ff && state_ff == bqc_pkg::ST_IDLE, "finished result was not presented")

endmodule

// ===== rtl/bqc_alu.sv =====
// shared multiplier and accumulators that evaluate one biquad section
module bqc_alu (
   input  logic                                    clock,
   input  bqc_pkg::alu_ctl_type                    ctl,
   input  logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] sample_in,
   input  logic signed [bqc_pkg::COEF_WIDTH-1:0]   coef,
   input  logic signed [bqc_pkg::DELAY_WIDTH-1:0]  z1,
   input  logic signed [bqc_pkg::DELAY_WIDTH-1:0]  z2,
   output logic signed [bqc_pkg::SAMPLE_WIDTH-1:0] y,
   output logic signed [bqc_pkg::DELAY_WIDTH-1:0]  z1_new,
   output logic signed [bqc_pkg::DELAY_WIDTH-1:0]  z2_new
);

   localparam int SW     = bqc_pkg::SAMPLE_WIDTH;
   localparam int DW     = bqc_pkg::DELAY_WIDTH;
   localparam int PROD_W = bqc_pkg::COEF_WIDTH + bqc_pkg::SAMPLE_WIDTH;
   localparam int RND_W  = PROD_W - bqc_pkg::COEF_FRAC;
   localparam int ACC_W  = ((DW > RND_W) ? DW : RND_W) + 2;

   localparam logic signed [PROD_W-1:0] ROUND_ADD =
      PROD_W'(1) <<< (bqc_pkg::COEF_FRAC - 1);
   localparam logic signed [ACC_W-1:0] SMP_MAX = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SMP_MIN = ~SMP_MAX;
   localparam logic signed [ACC_W-1:0] DLY_MAX = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] DLY_MIN = ~DLY_MAX;

   // round half up: add half an lsb, then floor by dropping the fraction
   function automatic logic signed [RND_W-1:0] mul_round(
      input logic signed [bqc_pkg::COEF_WIDTH-1:0] c,
      input logic signed [SW-1:0]                  v
   );
      logic signed [PROD_W-1:0] p;
      p = PROD_W'(c) * PROD_W'(v);
      p = p + ROUND_ADD;
      return p[PROD_W-1:bqc_pkg::COEF_FRAC];
   endfunction

   function automatic logic signed [SW-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
      logic signed [SW-1:0] r;
      if (v > SMP_MAX) begin
         r = SMP_MAX[SW-1:0];
      end else if (v < SMP_MIN) begin
         r = SMP_MIN[SW-1:0];
      end else begin
         r = v[SW-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DW-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
      logic signed [DW-1:0] r;
      if (v > DLY_MAX) begin
         r = DLY_MAX[DW-1:0];
      end else if (v < DLY_MIN) begin
         r = DLY_MIN[DW-1:0];
      end else begin
         r = v[DW-1:0];
      end
      return r;
   endfunction

   logic signed [SW-1:0]    x_ff;
   logic signed [SW-1:0]    y_ff;
   logic signed [RND_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc1_ff;
   logic signed [ACC_W-1:0] acc2_ff;
   logic signed [DW-1:0]    z1n_ff;

   logic signed [SW-1:0]    mul_opnd;
   logic signed [RND_W-1:0] prod_in;

   // feedback products take the section output, feedforward ones the input
   always_comb begin
      if (ctl.step == bqc_pkg::STEP_A1 || ctl.step == bqc_pkg::STEP_A2) begin
         mul_opnd = y_ff;
      end else begin
         mul_opnd = x_ff;
      end
      prod_in = mul_round(coef, mul_opnd);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_x) begin
         x_ff <= sample_in;
         y_ff <= sample_in;
      end else if (ctl.run) begin
         unique case (ctl.step)
            bqc_pkg::STEP_B0: begin
               prod_ff <= prod_in;
            end
            bqc_pkg::STEP_B1: begin
               y_ff    <= sat_sample(ACC_W'(prod_ff) + ACC_W'(z1));
               prod_ff <= prod_in;
            end
            bqc_pkg::STEP_B2: begin
               acc1_ff <= ACC_W'(prod_ff) + ACC_W'(z2);
               prod_ff <= prod_in;
            end
            bqc_pkg::STEP_A1: begin
               acc2_ff <= ACC_W'(prod_ff);
               prod_ff <= prod_in;
            end
            bqc_pkg::STEP_A2: begin
               z1n_ff  <= sat_delay(acc1_ff - ACC_W'(prod_ff));
               prod_ff <= prod_in;
            end
            bqc_pkg::STEP_WB: begin
               x_ff <= y_ff;
            end
            default: begin
               prod_ff <= prod_ff;
            end
         endcase
      end
   end

   assign y      = y_ff;
   assign z1_new = z1n_ff;
   assign z2_new = sat_delay(acc2_ff - ACC_W'(prod_ff));

endmodule

// ===== test/tb_biquad_cascade_iir_filter.sv =====
// self-checking testbench of the cascaded biquad iir filter
`timescale 1ns / 1ps

module tb_biquad_cascade_iir_filter;
   import bqc_pkg::*;

   // function code that the block treats as a no-op
   localparam logic [1:0] FUNC_NONE = 2'd3;

   // coefficient slots of one section, in table order
   localparam logic [2:0] COEF_B0 = 3'd0;
   localparam logic [2:0] COEF_B1 = 3'd1;
   localparam logic [2:0] COEF_B2 = 3'd2;
   localparam logic [2:0] COEF_A1 = 3'd3;
   localparam logic [2:0] COEF_A2 = 3'd4;

   localparam logic [CSR_AW-1:0] ADDR_ACTIVE_STAGES = CSR_AW'(4 * REG_ACTIVE_STAGES);

   // Q4.16 one and the sample and coefficient extremes
   localparam int UNITY      = 1 << COEF_FRAC;
   localparam int SAMPLE_MAX = (1 << (SAMPLE_WIDTH - 1)) - 1;
   localparam int SAMPLE_MIN = -(1 << (SAMPLE_WIDTH - 1));
   localparam int COEF_MAX   = (1 << (COEF_WIDTH - 1)) - 1;
   localparam int COEF_MIN   = -(1 << (COEF_WIDTH - 1));

   // settle tail long enough for a full cascade of eight sections, so it covers any job in flight
   localparam int TAIL_CYCLES = 64;
   localparam int HOLD_CYCLES = 600;
   localparam int CYCLE_LIMIT = 500000;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [1:0]                     req_func;
   logic signed [SAMPLE_WIDTH-1:0] req_sample_in;
   logic [2:0]                     req_stage_select;
   logic [2:0]                     req_coef_select;
   logic signed [COEF_WIDTH-1:0]   req_coef_value;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [CSR_AW-1:0]              csr_paddr;
   logic [CSR_DW-1:0]              csr_pwdata;
   logic [CSR_DW-1:0]              csr_prdata;
   logic                           csr_pready;

   // predicted filter state: coefficient table, delay pairs, section count
   longint                  coef_mem [MAX_STAGES][NUM_COEFS];
   longint                  z1_state [MAX_STAGES];
   longint                  z2_state [MAX_STAGES];
   logic [ACTIVE_WIDTH-1:0] stage_count;

   // filtered samples still owed by the block, oldest first
   logic signed [SAMPLE_WIDTH-1:0] expected_samples [$];
   logic signed [SAMPLE_WIDTH-1:0] wanted_sample;

   int error_count = 0;
   int cycle_count = 0;

   // idle rates in percent, changed per phase
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;

   // long receiver hold-off: the test bumps the ticket, the stall process serves it
   int hold_ticket = 0;
   int hold_served = 0;
   int hold_left   = 0;

   // sections tried in turn by the random phases before going fully random
   int stage_plan [8] = '{8, 0, 15, 1, 3, 12, 5, 2};
   int plan_index = 0;

   biquad_cascade_iir_filter DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_sample_in    (req_sample_in),
      .req_stage_select (req_stage_select),
      .req_coef_select  (req_coef_select),
      .req_coef_value   (req_coef_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver stall: a pending hold-off wins, otherwise random at the phase rate
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_ticket != hold_served) begin
         hold_served <= hold_ticket;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------- prediction

   // coef * sample rounded half up to the sample lsb
   function automatic longint round_product(input longint coef, input longint x);
      return (coef * x + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
   endfunction

   function automatic longint clamp(input longint v, input int w);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // pushes one sample through the active sections, updating the delay pairs
   function automatic logic signed [SAMPLE_WIDTH-1:0] run_cascade(
      input logic signed [SAMPLE_WIDTH-1:0] sample);
      int     n;
      longint x;
      longint y;
      n = (int'(stage_count) > MAX_STAGES) ? MAX_STAGES : int'(stage_count);
      x = sample;
      for (int s = 0; s < n; s++) begin
         y = clamp(round_product(coef_mem[s][COEF_B0], x) + z1_state[s], SAMPLE_WIDTH);
         z1_state[s] = clamp(round_product(coef_mem[s][COEF_B1], x)
                             - round_product(coef_mem[s][COEF_A1], y) + z2_state[s],
                             DELAY_WIDTH);
         z2_state[s] = clamp(round_product(coef_mem[s][COEF_B2], x)
                             - round_product(coef_mem[s][COEF_A2], y), DELAY_WIDTH);
         x = y;
      end
      return x[SAMPLE_WIDTH-1:0];
   endfunction

   // applies one accepted transaction to the predicted state
   function automatic void apply_request(input logic [1:0] func,
                                         input logic signed [SAMPLE_WIDTH-1:0] sample,
                                         input logic [2:0] stage,
                                         input logic [2:0] sel,
                                         input logic signed [COEF_WIDTH-1:0] value);
      case (func)
         FUNC_FILTER: begin
            expected_samples.push_back(run_cascade(sample));
         end
         FUNC_WRITE: begin
            // slots past a2 are not coefficients and write nothing
            if (stage < MAX_STAGES && sel <= COEF_A2)
               coef_mem[stage][sel] = value;
         end
         FUNC_CLEAR: begin
            // coefficients survive a clear
            for (int s = 0; s < MAX_STAGES; s++) begin
               z1_state[s] = 0;
               z2_state[s] = 0;
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   // outputs only move at the rising edge, so the value at the falling edge is what
   // the next rising edge takes
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            $error("sample_out: no transaction expected, actual %0d", rsp_sample_out);
            error_count++;
         end else begin
            wanted_sample = expected_samples.pop_front();
            if (rsp_sample_out !== wanted_sample) begin
               $error("sample_out mismatch: expected %0d, actual %0d",
                      wanted_sample, rsp_sample_out);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // offers one transaction, holds it until taken, then updates the prediction
   task automatic send_item(input logic [1:0] func,
                            input logic signed [SAMPLE_WIDTH-1:0] sample,
                            input logic [2:0] stage,
                            input logic [2:0] sel,
                            input logic signed [COEF_WIDTH-1:0] value);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_sample_in    <= sample;
      req_stage_select <= stage;
      req_coef_select  <= sel;
      req_coef_value   <= value;
      @(negedge clock);
      while (req_stall) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      apply_request(func, sample, stage, sel, value);
   endtask

   task automatic send_sample(input int sample);
      send_item(FUNC_FILTER, SAMPLE_WIDTH'(sample), 3'd0, COEF_B0, '0);
   endtask

   task automatic send_coef(input int stage, input logic [2:0] sel, input int value);
      send_item(FUNC_WRITE, '0, 3'(stage), sel, COEF_WIDTH'(value));
   endtask

   // stops offering and waits until every owed sample is out, plus a tail for
   // transactions that return nothing
   task automatic settle_block(input int tail);
      req_valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_AW-1:0] addr, input logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_AW-1:0] addr, output logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) begin
         @(posedge clock);
         @(negedge clock);
      end
      data = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_stage_count();
      logic [CSR_DW-1:0] readback;
      csr_read(ADDR_ACTIVE_STAGES, readback);
      if (readback !== CSR_DW'(stage_count)) begin
         $error("active_stages mismatch: expected %0d, actual %0d", stage_count, readback);
         error_count++;
      end
   endtask

   // register write only once the block has gone quiet; upper bits are junk
   task automatic set_stage_count(input int count);
      logic [CSR_DW-1:0] word;
      settle_block(TAIL_CYCLES);
      word = $urandom;
      word[ACTIVE_WIDTH-1:0] = ACTIVE_WIDTH'(count);
      csr_write(ADDR_ACTIVE_STAGES, word);
      stage_count = ACTIVE_WIDTH'(count);
      check_stage_count();
   endtask

   // ---------------------------------------------------------------- random content

   function automatic int random_sample();
      case ($urandom_range(9))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         default: return int'($signed(SAMPLE_WIDTH'($urandom)));
      endcase
   endfunction

   // mostly a filter that stays near unity gain, now and then anything at all
   function automatic int random_coef(input logic [2:0] sel);
      if ($urandom_range(99) < 20)
         return int'($signed(COEF_WIDTH'($urandom)));
      if (sel >= COEF_A1)
         return int'($urandom_range(UNITY)) - UNITY / 2;
      return int'($urandom_range(2 * UNITY)) - UNITY;
   endfunction

   task automatic send_random_item();
      int          pick;
      logic [2:0]  sel;
      pick = $urandom_range(99);
      if (pick < 70) begin
         send_sample(random_sample());
      end else if (pick < 90) begin
         sel = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
         send_coef($urandom_range(MAX_STAGES - 1), sel, random_coef(sel));
      end else if (pick < 95) begin
         send_item(FUNC_CLEAR, SAMPLE_WIDTH'($urandom), 3'($urandom), 3'($urandom),
                   COEF_WIDTH'($urandom));
      end else begin
         send_item(FUNC_NONE, SAMPLE_WIDTH'($urandom), 3'($urandom), 3'($urandom),
                   COEF_WIDTH'($urandom));
      end
   endtask

   // ---------------------------------------------------------------- tests

   // reset value of the section count, then write and read back its extremes
   task automatic test_register_access();
      check_stage_count();
      set_stage_count(15);
      set_stage_count(0);
      set_stage_count(8);
      set_stage_count(1);
   endtask

   // one section at the extremes, ignored writes, no-op, clear, section count edges
   task automatic test_directed();
      // zero coefficients out of reset give silence
      send_sample(SAMPLE_MAX);
      send_coef(0, COEF_B0, UNITY);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      // most negative gain saturates both ways
      send_coef(0, COEF_B0, COEF_MIN);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_coef(0, COEF_B1, COEF_MAX);
      send_coef(0, COEF_B2, COEF_MIN);
      send_coef(0, COEF_A1, COEF_MAX);
      send_coef(0, COEF_A2, COEF_MIN);
      // slots past a2 must leave the table alone
      send_coef(0, 3'd5, COEF_MAX);
      send_coef(0, 3'd7, -1);
      send_sample(SAMPLE_MAX);
      send_sample(-1);
      send_item(FUNC_NONE, SAMPLE_WIDTH'(SAMPLE_MAX), 3'd7, 3'd7, COEF_WIDTH'(COEF_MIN));
      send_sample(0);
      send_item(FUNC_CLEAR, '0, '0, '0, '0);
      send_sample(1);
      send_coef(MAX_STAGES - 1, COEF_A2, -1);
      send_coef(0, COEF_B0, UNITY);
      // no sections: straight through
      set_stage_count(0);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      // counts above the built sections act as all of them
      set_stage_count(15);
      send_sample(12345);
      set_stage_count(MAX_STAGES);
      send_sample(-12345);
   endtask

   // random traffic in chunks, each chunk under its own section count
   task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                      input int count);
      int chunk;
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 45 == 0) begin
            chunk = (plan_index < 8) ? stage_plan[plan_index] : $urandom_range(15);
            plan_index++;
            set_stage_count(chunk);
         end
         send_random_item();
      end
   endtask

   // receiver holds off for a long stretch while the sender keeps offering full cascades
   task automatic test_backpressure();
      set_stage_count(MAX_STAGES);
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      hold_ticket <= hold_ticket + 1;
      for (int i = 0; i < 30; i++)
         send_sample(random_sample());
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = FUNC_FILTER;
      req_sample_in    = '0;
      req_stage_select = '0;
      req_coef_select  = COEF_B0;
      req_coef_value   = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = ADDR_ACTIVE_STAGES;
      csr_pwdata       = '0;
      stage_count      = ACTIVE_WIDTH'(1);
      for (int s = 0; s < MAX_STAGES; s++) begin
         z1_state[s] = 0;
         z2_state[s] = 0;
         for (int c = 0; c < NUM_COEFS; c++)
            coef_mem[s][c] = 0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_directed();
      test_random_traffic(6, 66, 200);
      test_backpressure();
      test_random_traffic(66, 6, 200);
      test_random_traffic(0, 0, 200);

      settle_block(TAIL_CYCLES);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
